/* hdl/flight_phase_roll_controller_assert.svh */
// Assertion shorthands shared by the RTL. Sampled on clk, off while arst_n is low.
`ifndef FLIGHT_PHASE_ROLL_CONTROLLER_ASSERT_SVH
`define FLIGHT_PHASE_ROLL_CONTROLLER_ASSERT_SVH

// Same-cycle implication.
`define FPRC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define FPRC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/fprc_pkg.sv */
`default_nettype none

package fprc_pkg;

	// Phase codes
	localparam logic [2:0] PH_IDLE    = 3'd0;
	localparam logic [2:0] PH_LAUNCH  = 3'd1;
	localparam logic [2:0] PH_BOOST   = 3'd2;
	localparam logic [2:0] PH_BURNOUT = 3'd3;
	localparam logic [2:0] PH_COAST   = 3'd4;

	// Register indexes
	localparam logic [2:0] REG_LAUNCH_ACCEL_THRESHOLD = 3'd0;
	localparam logic [2:0] REG_LAUNCH_HOLD_TICKS      = 3'd1;
	localparam logic [2:0] REG_COAST_ACCEL_THRESHOLD  = 3'd2;
	localparam logic [2:0] REG_COAST_HOLD_TICKS       = 3'd3;
	localparam logic [2:0] REG_ROLL_GAIN              = 3'd4;
	localparam logic [2:0] REG_ROLL_DEADBAND          = 3'd5;
	localparam logic [2:0] REG_ROLL_CUTOFF_ALTITUDE   = 3'd6;
	localparam logic [2:0] REG_INITIAL_ANGLE          = 3'd7;

	// Register reset values
	localparam logic signed [15:0] RST_LAUNCH_ACCEL_THRESHOLD = 16'sd16384;
	localparam logic [31:0]        RST_LAUNCH_HOLD_TICKS      = 32'd1000;
	localparam logic signed [15:0] RST_COAST_ACCEL_THRESHOLD  = 16'sd0;
	localparam logic [31:0]        RST_COAST_HOLD_TICKS       = 32'd1000;
	localparam logic [15:0]        RST_ROLL_GAIN              = 16'd256;
	localparam logic [14:0]        RST_ROLL_DEADBAND          = 15'd0;
	localparam logic signed [19:0] RST_ROLL_CUTOFF_ALTITUDE   = 20'sd0;
	localparam logic [7:0]         RST_INITIAL_ANGLE          = 8'd0;

	localparam int CLAMP_SPAN = 15;
	localparam int ANGLE_MAX  = 180;

	typedef struct packed {
		logic signed [15:0] accel_z;
		logic [31:0]        time_now;
		logic signed [15:0] roll_rate_in;
		logic signed [19:0] altitude_in;
	} sample_t;

	typedef struct packed {
		logic [2:0] flight_phase;
		logic       servo_write;
		logic [7:0] servo_angle;
	} result_t;

	typedef struct packed {
		logic signed [15:0] launch_accel_threshold;
		logic [31:0]        launch_hold_ticks;
		logic signed [15:0] coast_accel_threshold;
		logic [31:0]        coast_hold_ticks;
		logic [15:0]        roll_gain;
		logic [14:0]        roll_deadband;
		logic signed [19:0] roll_cutoff_altitude;
		logic [7:0]         initial_angle;
	} cfg_t;

endpackage

`default_nettype wire

/* hdl/fprc_sample_if.sv */
`default_nettype none

interface fprc_sample_if;
	import fprc_pkg::*;

	logic    valid;
	logic    ready;
	sample_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

/* hdl/fprc_result_if.sv */
`default_nettype none

interface fprc_result_if;
	import fprc_pkg::*;

	logic    valid;
	logic    ready;
	result_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

/* hdl/fprc_cfg_if.sv */
`default_nettype none

interface fprc_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hdl/fprc_cfg_regs.sv */
`default_nettype none

module fprc_cfg_regs (
	input  wire logic           clk,
	input  wire logic           arst_n,
	fprc_cfg_if.sink            cfg,
	output fprc_pkg::cfg_t      regs
);
	import fprc_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.launch_accel_threshold <= RST_LAUNCH_ACCEL_THRESHOLD;
			regs_q.launch_hold_ticks      <= RST_LAUNCH_HOLD_TICKS;
			regs_q.coast_accel_threshold  <= RST_COAST_ACCEL_THRESHOLD;
			regs_q.coast_hold_ticks       <= RST_COAST_HOLD_TICKS;
			regs_q.roll_gain              <= RST_ROLL_GAIN;
			regs_q.roll_deadband          <= RST_ROLL_DEADBAND;
			regs_q.roll_cutoff_altitude   <= RST_ROLL_CUTOFF_ALTITUDE;
			regs_q.initial_angle          <= RST_INITIAL_ANGLE;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_LAUNCH_ACCEL_THRESHOLD: regs_q.launch_accel_threshold <= cfg.data[15:0];
				REG_LAUNCH_HOLD_TICKS:      regs_q.launch_hold_ticks      <= cfg.data;
				REG_COAST_ACCEL_THRESHOLD:  regs_q.coast_accel_threshold  <= cfg.data[15:0];
				REG_COAST_HOLD_TICKS:       regs_q.coast_hold_ticks       <= cfg.data;
				REG_ROLL_GAIN:              regs_q.roll_gain              <= cfg.data[15:0];
				REG_ROLL_DEADBAND:          regs_q.roll_deadband          <= cfg.data[14:0];
				REG_ROLL_CUTOFF_ALTITUDE:   regs_q.roll_cutoff_altitude   <= cfg.data[19:0];
				REG_INITIAL_ANGLE:          regs_q.initial_angle          <= cfg.data[7:0];
			endcase
		end
	end

endmodule

`default_nettype wire

/* hdl/fprc_phase_fsm.sv */
`default_nettype none
`include "flight_phase_roll_controller_assert.svh"

module fprc_phase_fsm #(
	parameter int TIMESTAMP_BITS = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             advance,
	input  wire fprc_pkg::sample_t smp,
	input  wire fprc_pkg::cfg_t   regs,
	output logic [2:0]            next_phase
);
	import fprc_pkg::*;

	localparam int TW = TIMESTAMP_BITS;
	localparam int CW = (TW > 32) ? TW : 32;

	logic [2:0]    phase_q;
	logic [TW-1:0] launch_start_q;
	logic [TW-1:0] burnout_start_q;

	logic [CW-1:0] now_ext;
	logic [TW-1:0] now_ts;
	logic [TW-1:0] launch_elapsed;
	logic [TW-1:0] burnout_elapsed;
	logic          launch_held;
	logic          burnout_held;

	assign now_ext         = CW'(smp.time_now);
	assign now_ts          = now_ext[TW-1:0];
	assign launch_elapsed  = now_ts - launch_start_q;
	assign burnout_elapsed = now_ts - burnout_start_q;
	assign launch_held     = CW'(launch_elapsed) > CW'(regs.launch_hold_ticks);
	assign burnout_held    = CW'(burnout_elapsed) > CW'(regs.coast_hold_ticks);

	always_comb begin
		next_phase = phase_q;
		unique case (phase_q)
			PH_IDLE: begin
				if (smp.accel_z > regs.launch_accel_threshold) next_phase = PH_LAUNCH;
			end
			PH_LAUNCH: begin
				if (smp.accel_z < regs.launch_accel_threshold) next_phase = PH_IDLE;
				else if (launch_held) next_phase = PH_BOOST;
			end
			PH_BOOST: begin
				if (smp.accel_z < regs.coast_accel_threshold) next_phase = PH_BURNOUT;
			end
			PH_BURNOUT: begin
				if (smp.accel_z > regs.coast_accel_threshold) next_phase = PH_BOOST;
				else if (burnout_held) next_phase = PH_COAST;
			end
			default: next_phase = phase_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_IDLE;
			launch_start_q  <= '0;
			burnout_start_q <= '0;
		end else if (advance) begin
			phase_q <= next_phase;
			if (phase_q == PH_IDLE && next_phase == PH_LAUNCH) launch_start_q <= now_ts;
			if (phase_q == PH_BOOST && next_phase == PH_BURNOUT) burnout_start_q <= now_ts;
		end
	end

	`FPRC_ASSERT_NEXT(a_coast_terminal, phase_q == PH_COAST, phase_q == PH_COAST,
		"phase left coast")
	`FPRC_ASSERT_NEXT(a_idle_exit, phase_q == PH_IDLE,
		phase_q == PH_IDLE || phase_q == PH_LAUNCH, "idle moved past launch detect")
	`FPRC_ASSERT_NEXT(a_launch_stamp,
		advance && phase_q == PH_IDLE && next_phase == PH_LAUNCH,
		launch_start_q == $past(now_ts), "launch start time not captured")

endmodule

`default_nettype wire

/* hdl/fprc_roll_law.sv */
`default_nettype none

module fprc_roll_law (
	input  wire fprc_pkg::cfg_t    regs,
	input  wire logic signed [15:0] spin_rate,
	input  wire logic signed [19:0] altitude,
	output logic [7:0]             angle
);
	import fprc_pkg::*;

	logic signed [16:0] gain_s;
	logic signed [32:0] prod;
	logic signed [33:0] neg_prod;
	logic signed [33:0] theta_full;
	logic signed [4:0]  theta_c;
	logic signed [16:0] rate_x;
	logic signed [16:0] db_x;
	logic signed [9:0]  init_x;
	logic signed [9:0]  raw;
	logic               active;

	assign gain_s   = signed'({1'b0, regs.roll_gain});
	assign prod     = gain_s * spin_rate;
	assign neg_prod = -(34'(prod));
	// divide by 256 rounding toward zero
	assign theta_full = (neg_prod + (neg_prod[33] ? 34'sd255 : 34'sd0)) >>> 8;

	always_comb begin
		if (theta_full > 34'(CLAMP_SPAN)) theta_c = 5'(CLAMP_SPAN);
		else if (theta_full < -34'(CLAMP_SPAN)) theta_c = -5'(CLAMP_SPAN);
		else theta_c = theta_full[4:0];
	end

	assign rate_x = 17'(spin_rate);
	assign db_x   = signed'({2'b00, regs.roll_deadband});
	assign active = (rate_x > db_x || rate_x < -db_x) &&
		(altitude < regs.roll_cutoff_altitude);

	assign init_x = signed'({2'b00, regs.initial_angle});
	assign raw    = active ? (init_x + 10'(theta_c)) : init_x;

	always_comb begin
		if (raw < 10'sd0) angle = 8'd0;
		else if (raw > 10'(ANGLE_MAX)) angle = 8'(ANGLE_MAX);
		else angle = raw[7:0];
	end

endmodule

`default_nettype wire

/* hdl/flight_phase_roll_controller.sv */
// Flight phase sequencer with proportional roll control. One sample goes in per beat
// on the sample channel and exactly one result comes out per sample on the result
// channel. A sample beat loads the input register; its result moves into the result
// register once that is empty or being read, and is offered from then on. A new sample
// is taken every clock while the result channel keeps up (the phase update and the
// single gain multiply are both combinational). A result waiting on the result channel
// holds up the input only once the input register is full as well.
// Config registers by index: 0 launch accel threshold, 1 launch hold ticks, 2 coast
// accel threshold, 3 coast hold ticks, 4 roll gain (Q8.8), 5 roll deadband, 6 roll
// cutoff altitude, 7 initial angle; write them only while no sample is in flight.
`default_nettype none
`include "flight_phase_roll_controller_assert.svh"

module flight_phase_roll_controller #(
	parameter int TIMESTAMP_BITS = 32
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	fprc_sample_if.sink sample,
	fprc_result_if.source result,
	fprc_cfg_if.sink    cfg
);
	import fprc_pkg::*;

	cfg_t       regs;
	sample_t    smp_s1;
	logic       valid_s1;
	result_t    res_s2;
	logic       valid_s2;
	logic       advance;
	logic       take;
	logic [2:0] next_phase;
	logic [7:0] law_angle;
	logic       coast;

	assign advance      = valid_s1 && (!valid_s2 || result.ready);
	assign sample.ready = !valid_s1 || advance;
	assign take         = sample.valid && sample.ready;

	fprc_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	fprc_phase_fsm #(
		.TIMESTAMP_BITS (TIMESTAMP_BITS)
	) u_fsm (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.smp        (smp_s1),
		.regs       (regs),
		.next_phase (next_phase)
	);

	fprc_roll_law u_law (
		.regs      (regs),
		.spin_rate (smp_s1.roll_rate_in),
		.altitude  (smp_s1.altitude_in),
		.angle     (law_angle)
	);

	assign coast = (next_phase == PH_COAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take) valid_s1 <= 1'b1;
			else if (advance) valid_s1 <= 1'b0;
			if (advance) valid_s2 <= 1'b1;
			else if (result.ready) valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) smp_s1 <= sample.data;
		if (advance) begin
			res_s2.flight_phase <= next_phase;
			res_s2.servo_write  <= coast;
			res_s2.servo_angle  <= coast ? law_angle : 8'd0;
		end
	end

	assign result.valid = valid_s2;
	assign result.data  = res_s2;

	`FPRC_ASSERT_NOW(a_write_in_coast, result.valid,
		result.data.servo_write == (result.data.flight_phase == PH_COAST),
		"servo write disagrees with phase")
	`FPRC_ASSERT_NOW(a_angle_range, result.valid,
		result.data.servo_angle <= 8'(ANGLE_MAX), "servo angle above limit")
	`FPRC_ASSERT_NEXT(a_stall_holds_s1, valid_s1 && !advance,
		valid_s1 && $stable(smp_s1), "input register lost a stalled sample")

endmodule

`default_nettype wire

/* verif/fprc_flight_checker.sv */
`default_nettype none

module fprc_flight_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	fprc_sample_if   sample_bus,
	fprc_result_if   result_bus,
	fprc_cfg_if      cfg_bus,
	output int       mismatches,
	output int       pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import fprc_pkg::*;

	cfg_t        regs;
	logic [2:0]  phase;
	logic [31:0] launch_t0;
	logic [31:0] burnout_t0;
	result_t     awaited_q[$];
	result_t     head;

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// advances the phase sequencer by one sample and returns the result it should produce
	function automatic result_t fly(input sample_t s);
		result_t r;
		longint  init;
		longint  db;
		longint  rate;
		longint  theta;
		longint  ang;
		case (phase)
			PH_IDLE: begin
				if (s.accel_z > regs.launch_accel_threshold) begin
					launch_t0 = s.time_now;
					phase = PH_LAUNCH;
				end
			end
			PH_LAUNCH: begin
				if (s.accel_z < regs.launch_accel_threshold)
					phase = PH_IDLE;
				else if (s.time_now - launch_t0 > regs.launch_hold_ticks)
					phase = PH_BOOST;
			end
			PH_BOOST: begin
				if (s.accel_z < regs.coast_accel_threshold) begin
					burnout_t0 = s.time_now;
					phase = PH_BURNOUT;
				end
			end
			PH_BURNOUT: begin
				if (s.accel_z > regs.coast_accel_threshold)
					phase = PH_BOOST;
				else if (s.time_now - burnout_t0 > regs.coast_hold_ticks)
					phase = PH_COAST;
			end
			default: ;
		endcase
		r = '0;
		r.flight_phase = phase;
		// servo follows the phase after the update, so the entering sample already steers
		if (phase == PH_COAST) begin
			init = regs.initial_angle;
			db = regs.roll_deadband;
			rate = s.roll_rate_in;
			ang = init;
			if ((rate > db || rate < -db) && s.altitude_in < regs.roll_cutoff_altitude) begin
				theta = longint'(regs.roll_gain) * -rate / 256;
				ang = clip(init + theta, init - CLAMP_SPAN, init + CLAMP_SPAN);
			end
			r.servo_write = 1'b1;
			r.servo_angle = 8'(clip(ang, 0, ANGLE_MAX));
		end
		return r;
	endfunction

	task automatic report(input string what, input int got, input int want);
		mismatches++;
		if (mismatches <= 40)
			$display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs = '{
				launch_accel_threshold: RST_LAUNCH_ACCEL_THRESHOLD,
				launch_hold_ticks:      RST_LAUNCH_HOLD_TICKS,
				coast_accel_threshold:  RST_COAST_ACCEL_THRESHOLD,
				coast_hold_ticks:       RST_COAST_HOLD_TICKS,
				roll_gain:              RST_ROLL_GAIN,
				roll_deadband:          RST_ROLL_DEADBAND,
				roll_cutoff_altitude:   RST_ROLL_CUTOFF_ALTITUDE,
				initial_angle:          RST_INITIAL_ANGLE
			};
			phase = PH_IDLE;
			launch_t0 = '0;
			burnout_t0 = '0;
			awaited_q.delete();
			mismatches = 0;
			pending <= 0;
		end else begin
			if (cfg_bus.valid && cfg_bus.ready) begin
				case (cfg_bus.index)
					REG_LAUNCH_ACCEL_THRESHOLD: regs.launch_accel_threshold = cfg_bus.data[15:0];
					REG_LAUNCH_HOLD_TICKS:      regs.launch_hold_ticks = cfg_bus.data;
					REG_COAST_ACCEL_THRESHOLD:  regs.coast_accel_threshold = cfg_bus.data[15:0];
					REG_COAST_HOLD_TICKS:       regs.coast_hold_ticks = cfg_bus.data;
					REG_ROLL_GAIN:              regs.roll_gain = cfg_bus.data[15:0];
					REG_ROLL_DEADBAND:          regs.roll_deadband = cfg_bus.data[14:0];
					REG_ROLL_CUTOFF_ALTITUDE:   regs.roll_cutoff_altitude = cfg_bus.data[19:0];
					REG_INITIAL_ANGLE:          regs.initial_angle = cfg_bus.data[7:0];
					default: ;
				endcase
			end
			// results first: a result beat never belongs to a sample taken on the same edge
			if (result_bus.valid && result_bus.ready) begin
				if (awaited_q.size() == 0) begin
					report("unexpected result, phase", result_bus.data.flight_phase, -1);
				end else begin
					head = awaited_q.pop_front();
					if (result_bus.data.flight_phase !== head.flight_phase)
						report("flight_phase", result_bus.data.flight_phase, head.flight_phase);
					if (result_bus.data.servo_write !== head.servo_write)
						report("servo_write", result_bus.data.servo_write, head.servo_write);
					if (result_bus.data.servo_angle !== head.servo_angle)
						report("servo_angle", result_bus.data.servo_angle, head.servo_angle);
				end
			end
			if (sample_bus.valid && sample_bus.ready)
				awaited_q.push_back(fly(sample_bus.data));
			pending <= awaited_q.size();
		end
	end
endmodule

`default_nettype wire

/* verif/tb_top.sv */
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import fprc_pkg::*;

	logic clk = 1'b0;
	logic arst_n;

	fprc_sample_if sample_bus();
	fprc_result_if result_bus();
	fprc_cfg_if    cfg_bus();

	int mismatches;
	int pending;

	cfg_t        cur;
	logic [31:0] tick;
	int          tx_calm;
	int          rx_calm;
	int          n_samples;
	int          n_loads;
	int          n_coast;
	bit          coasting;

	logic signed [15:0] levels[4];

	flight_phase_roll_controller DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_bus),
		.result (result_bus),
		.cfg    (cfg_bus)
	);

	fprc_flight_checker flight_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample_bus (sample_bus),
		.result_bus (result_bus),
		.cfg_bus    (cfg_bus),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#5ms;
		$display("tb_top failed");
		$finish;
	end

	function automatic int clip(input int v, input int lo, input int hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// per-beat wait, with occasional stretches of back-to-back beats
	function automatic int pick_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 13);
	endfunction

	task automatic send(input sample_t s);
		int w;
		w = pick_wait(tx_calm);
		if (w > 0) begin
			sample_bus.valid <= 1'b0;
			repeat (w) @(posedge clk);
		end
		sample_bus.valid <= 1'b1;
		sample_bus.data <= s;
		do @(posedge clk); while (!sample_bus.ready);
		n_samples++;
		if (coasting)
			n_coast++;
	endtask

	task automatic send_fields(input logic signed [15:0] az, input logic [31:0] t,
			input logic signed [15:0] roll, input logic signed [19:0] alt);
		sample_t s;
		s = '{accel_z: az, time_now: t, roll_rate_in: roll, altitude_in: alt};
		send(s);
	endtask

	// samples clustered around the given accel threshold and the roll/altitude limits
	task automatic send_noisy(input logic signed [15:0] thr);
		sample_t s;
		int      r;
		if ($urandom_range(0, 9) < 7)
			s.accel_z = 16'(clip(int'(thr) + int'($urandom_range(0, 4)) - 2, -32768, 32767));
		else
			s.accel_z = 16'($urandom);
		r = $urandom_range(0, 19);
		if (r < 17)
			tick = tick + $urandom_range(0, 400);
		else if (r < 19)
			tick = $urandom;
		else
			tick = 32'hFFFF_FFFF - $urandom_range(0, 300);
		s.time_now = tick;
		if ($urandom_range(0, 1)) begin
			r = int'(cur.roll_deadband) + int'($urandom_range(0, 2)) - 1;
			if ($urandom_range(0, 1))
				r = -r;
			s.roll_rate_in = 16'(clip(r, -32768, 32767));
		end else begin
			s.roll_rate_in = 16'($urandom);
		end
		if ($urandom_range(0, 1))
			s.altitude_in = 20'(clip(int'(cur.roll_cutoff_altitude) +
				int'($urandom_range(0, 2)) - 1, -524288, 524287));
		else
			s.altitude_in = 20'($urandom);
		send(s);
	endtask

	task automatic drain();
		sample_bus.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic put_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= val;
		do @(posedge clk); while (!cfg_bus.ready);
	endtask

	// registers only change with the block empty
	task automatic apply_settings();
		drain();
		put_reg(REG_LAUNCH_ACCEL_THRESHOLD, 32'(cur.launch_accel_threshold));
		put_reg(REG_LAUNCH_HOLD_TICKS, cur.launch_hold_ticks);
		put_reg(REG_COAST_ACCEL_THRESHOLD, 32'(cur.coast_accel_threshold));
		put_reg(REG_COAST_HOLD_TICKS, cur.coast_hold_ticks);
		put_reg(REG_ROLL_GAIN, 32'(cur.roll_gain));
		put_reg(REG_ROLL_DEADBAND, 32'(cur.roll_deadband));
		put_reg(REG_ROLL_CUTOFF_ALTITUDE, 32'(cur.roll_cutoff_altitude));
		put_reg(REG_INITIAL_ANGLE, 32'(cur.initial_angle));
		cfg_bus.valid <= 1'b0;
		n_loads++;
	endtask

	initial begin
		result_bus.ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			int w;
			w = pick_wait(rx_calm);
			if (w > 0) begin
				result_bus.ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			result_bus.ready <= 1'b1;
			do @(posedge clk); while (!result_bus.valid);
		end
	end

	initial begin
		sample_bus.valid <= 1'b0;
		sample_bus.data <= '0;
		cfg_bus.valid <= 1'b0;
		cfg_bus.index <= REG_LAUNCH_ACCEL_THRESHOLD;
		cfg_bus.data <= '0;
		tick = '0;
		coasting = 1'b0;
		cur = '{
			launch_accel_threshold: RST_LAUNCH_ACCEL_THRESHOLD,
			launch_hold_ticks:      RST_LAUNCH_HOLD_TICKS,
			coast_accel_threshold:  RST_COAST_ACCEL_THRESHOLD,
			coast_hold_ticks:       RST_COAST_HOLD_TICKS,
			roll_gain:              RST_ROLL_GAIN,
			roll_deadband:          RST_ROLL_DEADBAND,
			roll_cutoff_altitude:   RST_ROLL_CUTOFF_ALTITUDE,
			initial_angle:          RST_INITIAL_ANGLE
		};
		do @(posedge clk); while (!arst_n);

		// idle/launch with the reset settings; hold is never exceeded here
		send_fields(16'sd16384, 32'd100, 16'sh8000, 20'sh80000);
		send_fields(16'sd16385, 32'd0, 16'sh7FFF, 20'sh7FFFF);
		send_fields(16'sd16383, 32'd50, 16'sd0, 20'sd0);
		send_fields(16'sh7FFF, 32'hFFFF_FF00, 16'sh7FFF, 20'sh80000);
		send_fields(16'sd16384, 32'h0000_02E8, 16'sh8000, 20'sh7FFFF);
		send_fields(16'sh8000, 32'hFFFF_FFFF, 16'sd1, 20'sd1);

		// launch detect never times out, so the sequencer stays in idle/launch
		cur.launch_hold_ticks = '1;
		levels = '{16'sd16384, 16'sh8000, 16'sh7FFF, 16'($urandom)};
		foreach (levels[k]) begin
			cur.launch_accel_threshold = levels[k];
			apply_settings();
			repeat (80) send_noisy(cur.launch_accel_threshold);
		end

		// into boost across a timestamp wrap, then burnout/boost bounce
		cur.launch_accel_threshold = 16'sd16384;
		cur.launch_hold_ticks = '0;
		cur.coast_accel_threshold = 16'sd0;
		cur.coast_hold_ticks = '1;
		apply_settings();
		send_fields(16'sh8000, 32'd7, 16'sd0, 20'sd0);
		send_fields(16'sd20000, 32'hFFFF_FFFF, 16'sd0, 20'sd0);
		send_fields(16'sd16384, 32'h0000_0000, 16'sd0, 20'sd0);
		send_fields(16'sd0, 32'd10, 16'sd0, 20'sd0);
		send_fields(-16'sd1, 32'hFFFF_FFF0, 16'sd0, 20'sd0);
		send_fields(16'sd0, 32'h0000_0010, 16'sd0, 20'sd0);
		send_fields(16'sd1, 32'h0000_0020, 16'sd0, 20'sd0);

		levels = '{16'sd0, 16'sh8000, 16'sh7FFF, 16'($urandom)};
		foreach (levels[k]) begin
			cur.coast_accel_threshold = levels[k];
			apply_settings();
			repeat (80) send_noisy(cur.coast_accel_threshold);
		end

		// enter coast; gain 1.5 shows truncation toward zero
		cur.coast_accel_threshold = 16'sd0;
		cur.coast_hold_ticks = '0;
		cur.initial_angle = 8'd90;
		cur.roll_gain = 16'h0180;
		cur.roll_deadband = 15'd2;
		cur.roll_cutoff_altitude = 20'sd1000;
		apply_settings();
		send_fields(16'sd100, 32'd1000, 16'sd0, 20'sd0);
		send_fields(-16'sd5, 32'd1000, 16'sd0, 20'sd0);
		send_fields(16'sd0, 32'd1000, 16'sd0, 20'sd0);
		coasting = 1'b1;
		send_fields(-16'sd1, 32'd1001, 16'sh8000, 20'sh80000);
		send_fields(16'sd0, 32'd2000, 16'sd2, 20'sd0);
		send_fields(16'sd0, 32'd2001, -16'sd2, 20'sd0);
		send_fields(16'sd0, 32'd2002, 16'sd3, 20'sd0);
		send_fields(16'sd0, 32'd2003, -16'sd3, 20'sd0);
		send_fields(16'sd0, 32'd2004, 16'sh7FFF, 20'sd999);
		send_fields(16'sd0, 32'd2005, 16'sh7FFF, 20'sd1000);

		for (int k = 0; k < 8; k++) begin
			case (k)
				0: begin
					cur.initial_angle = 8'd0;
					cur.roll_gain = 16'h0000;
					cur.roll_deadband = 15'd0;
					cur.roll_cutoff_altitude = 20'sh80000;
				end
				1: begin
					cur.initial_angle = 8'd180;
					cur.roll_gain = 16'hFFFF;
					cur.roll_deadband = 15'h7FFF;
					cur.roll_cutoff_altitude = 20'sh7FFFF;
				end
				2: begin
					// window centered above the servo range, result saturates
					cur.initial_angle = 8'd255;
					cur.roll_gain = 16'hFFFF;
					cur.roll_deadband = 15'd0;
					cur.roll_cutoff_altitude = 20'sh7FFFF;
				end
				3: begin
					cur.initial_angle = 8'd200;
					cur.roll_gain = 16'h0100;
					cur.roll_deadband = 15'd50;
					cur.roll_cutoff_altitude = 20'sd0;
				end
				4: begin
					cur.initial_angle = 8'd0;
					cur.roll_gain = 16'h0340;
					cur.roll_deadband = 15'd10;
					cur.roll_cutoff_altitude = 20'sd500;
				end
				default: begin
					cur.initial_angle = 8'($urandom_range(0, 255));
					cur.roll_gain = 16'($urandom);
					cur.roll_deadband = (k == 7) ? 15'($urandom) : 15'($urandom_range(0, 400));
					cur.roll_cutoff_altitude = 20'($urandom);
				end
			endcase
			// thresholds and holds no longer matter in coast; vary them anyway
			cur.launch_accel_threshold = 16'($urandom);
			cur.launch_hold_ticks = $urandom;
			cur.coast_accel_threshold = 16'($urandom);
			cur.coast_hold_ticks = $urandom;
			apply_settings();
			repeat (100) send_noisy(cur.coast_accel_threshold);
		end

		drain();
		repeat (8) @(posedge clk);
		$display("covered %0d samples over %0d register loads, %0d of them in coast",
			n_samples, n_loads, n_coast);
		if (mismatches == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end
endmodule

`default_nettype wire
